[hdl/lva_pkg.sv]
// lva_pkg: shared types, codes and constants for the lru voice allocator
// depends on nothing; imported by every module under hdl
package lva_pkg;

  localparam int VoiceCountDefault = 16;
  localparam int ZoneBitsDefault   = 6;
  localparam int MaxResults        = 16;

  localparam logic [2:0] ACT_NOTE_ON  = 3'd0;
  localparam logic [2:0] ACT_NOTE_OFF = 3'd1;
  localparam logic [2:0] ACT_ALL_OFF  = 3'd2;
  localparam logic [2:0] ACT_FINISHED = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_RETRIG  = 3'd1;
  localparam logic [2:0] CMD_STEAL   = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_STOP    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       zone_hit;
    logic [5:0] zone_id;
    logic [3:0] finished_voice;
  } req_t;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] voice;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic [5:0] out_zone;
    logic       last;
  } res_t;

  typedef struct packed {
    logic        vbusy;
    logic [6:0]  note;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic alloc;
    logic free_one;
    logic free_all;
  } tbl_ctl_t;

endpackage

[hdl/lva_voice_table.sv]
// lva_voice_table: per-voice busy flags, held notes and use stamps, plus the stamp counter
// depends on lva_pkg; one registered read port, one write port
module lva_voice_table import lva_pkg::*; #(
  parameter int VOICE_COUNT = VoiceCountDefault,
  parameter int IDX_W       = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd,
  input  tbl_ctl_t         ctl,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [6:0]       wr_note,
  input  logic [IDX_W-1:0] fin_idx
);

  logic [VOICE_COUNT-1:0] vbusy;
  logic [VOICE_COUNT-1:0] written;
  logic [31:0]            stamp_counter;
  logic [6:0]             note_mem [VOICE_COUNT];
  logic [31:0]            stamp_mem [VOICE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vbusy         <= '0;
      written       <= '0;
      stamp_counter <= '0;
    end else begin
      if (ctl.free_all) begin
        vbusy <= '0;
      end
      if (ctl.free_one) begin
        vbusy[fin_idx] <= 1'b0;
      end
      if (ctl.alloc) begin
        vbusy[wr_idx]   <= 1'b1;
        written[wr_idx] <= 1'b1;
        stamp_counter   <= stamp_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.alloc) begin
      note_mem[wr_idx]  <= wr_note;
      stamp_mem[wr_idx] <= stamp_counter + 32'd1;
    end
  end

  // entries never written read as their reset value of zero
  always_ff @(posedge clk) begin
    rd.vbusy <= vbusy[rd_idx];
    rd.note  <= written[rd_idx] ? note_mem[rd_idx] : 7'd0;
    rd.stamp <= written[rd_idx] ? stamp_mem[rd_idx] : 32'd0;
  end

endmodule

[hdl/lva_scan_unit.sv]
// lva_scan_unit: shared compare unit fed one voice entry per cycle
// depends on lva_pkg; tracks retrigger, free and oldest voices and flags release and stop matches
module lva_scan_unit import lva_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             init,
  input  logic             elem_v,
  input  logic [IDX_W-1:0] elem_idx,
  input  entry_t           elem,
  input  logic [2:0]       action,
  input  logic [6:0]       note,
  output logic             match,
  output logic [IDX_W-1:0] sel_idx,
  output logic [2:0]       sel_cmd
);

  logic             rt_found;
  logic [IDX_W-1:0] rt_idx;
  logic             fr_found;
  logic [IDX_W-1:0] fr_idx;
  logic [IDX_W-1:0] mn_idx;
  logic [31:0]      mn_stamp;
  logic             note_eq;

  assign note_eq = (elem.note == note);

  always_comb begin
    unique case (action)
      ACT_CLEAR:    match = 1'b1;
      ACT_ALL_OFF:  match = elem.vbusy;
      ACT_NOTE_OFF: match = elem.vbusy && note_eq;
      default:      match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || init) begin
      rt_found <= 1'b0;
      fr_found <= 1'b0;
    end else if (elem_v) begin
      if (!rt_found && elem.vbusy && note_eq) begin
        rt_found <= 1'b1;
      end
      if (!fr_found && !elem.vbusy) begin
        fr_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (elem_v) begin
      if (!rt_found && elem.vbusy && note_eq) begin
        rt_idx <= elem_idx;
      end
      if (!fr_found && !elem.vbusy) begin
        fr_idx <= elem_idx;
      end
      // oldest stamp, lowest index on a tie
      if (elem_idx == '0 || elem.stamp < mn_stamp) begin
        mn_idx   <= elem_idx;
        mn_stamp <= elem.stamp;
      end
    end
  end

  always_comb begin
    if (rt_found) begin
      sel_idx = rt_idx;
      sel_cmd = CMD_RETRIG;
    end else if (fr_found) begin
      sel_idx = fr_idx;
      sel_cmd = CMD_START;
    end else begin
      sel_idx = mn_idx;
      sel_cmd = CMD_STEAL;
    end
  end

endmodule

[hdl/lru_voice_allocator_unit.sv]
// lru_voice_allocator_unit: top level, sequencer, result register and port handshake
// depends on lva_pkg, lva_voice_table and lva_scan_unit
//
//   channel   ports                  accepted when
//   request   start, busy, request   start high and busy low
//   result    strobe, result         every cycle strobe is high
//
// note on with a zone hit, note off, all notes off and clear go through scan (each voice
// read in turn through the table read port), drain (the last read) and finish
// voice finished, note on without a zone hit and unknown actions stay in idle
// results leave at most one per cycle, each for one cycle; the last one comes in the
// same cycle as busy falls; rst is synchronous and clears the busy flags and the stamp
// counter, and stored notes and stamps then read as zero
module lru_voice_allocator_unit import lva_pkg::*; #(
  parameter int VOICE_COUNT = VoiceCountDefault,
  parameter int ZONE_BITS   = ZoneBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic strobe,
  output res_t result
);

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);
  localparam logic [5:0] ZONE_MASK =
    (ZONE_BITS >= 6) ? 6'h3f : 6'((1 << ZONE_BITS) - 1);

  state_t           state;
  state_t           state_next;
  req_t             req_q;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_d;
  logic             vld_d;
  logic             accept;
  tbl_ctl_t         ctl;
  entry_t           rd;
  logic             match;
  logic [IDX_W-1:0] sel_idx;
  logic [2:0]       sel_cmd;
  logic             pend_v;
  res_t             pend;
  logic [4:0]       cap;
  logic             fin_ok;
  logic [IDX_W+3:0] fin_ext;
  logic [IDX_W-1:0] fin_idx;
  logic [IDX_W+3:0] idx_d_ext;
  logic [IDX_W+3:0] sel_ext;
  logic             emit_mode;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign fin_ok    = (32'(request.finished_voice) < VOICE_COUNT);
  assign fin_ext   = {{IDX_W{1'b0}}, request.finished_voice};
  assign fin_idx   = fin_ext[IDX_W-1:0];
  assign idx_d_ext = {4'b0, idx_d};
  assign sel_ext   = {4'b0, sel_idx};
  assign emit_mode = (req_q.action != ACT_NOTE_ON);

  lva_voice_table #(
    .VOICE_COUNT(VOICE_COUNT),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (idx),
    .rd     (rd),
    .ctl    (ctl),
    .wr_idx (sel_idx),
    .wr_note(req_q.note),
    .fin_idx(fin_idx)
  );

  lva_scan_unit #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .init    (accept),
    .elem_v  (vld_d),
    .elem_idx(idx_d),
    .elem    (rd),
    .action  (req_q.action),
    .note    (req_q.note),
    .match   (match),
    .sel_idx (sel_idx),
    .sel_cmd (sel_cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (request.action) inside
            ACT_NOTE_ON: begin
              if (request.zone_hit) begin
                state_next = S_SCAN;
              end
            end
            ACT_NOTE_OFF, ACT_ALL_OFF: begin
              state_next = S_SCAN;
            end
            ACT_FINISHED: begin
              ctl.free_one = fin_ok;
            end
            ACT_CLEAR: begin
              ctl.free_all = 1'b1;
              state_next   = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.alloc  = (req_q.action == ACT_NOTE_ON);
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // scan address and the delayed index that lines up with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else begin
      vld_d <= (state == S_SCAN);
    end
    idx_d <= idx;
    if (state == S_SCAN) begin
      idx <= idx + 1'b1;
    end else begin
      idx <= '0;
    end
    if (accept) begin
      req_q <= request;
    end
  end

  // one pending release or stop is held back until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pend_v <= 1'b0;
      cap    <= '0;
    end else begin
      strobe <= 1'b0;
      if (accept) begin
        pend_v <= 1'b0;
        cap    <= '0;
      end else if (vld_d && emit_mode && match && cap < 5'(MaxResults)) begin
        if (pend_v) begin
          strobe <= 1'b1;
        end
        pend_v <= 1'b1;
        cap    <= cap + 5'd1;
      end else if (state == S_FINISH) begin
        strobe <= !emit_mode || pend_v;
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld_d && emit_mode && match && cap < 5'(MaxResults)) begin
      result            <= {pend[$bits(res_t)-1:1], 1'b0};
      pend.command      <= (req_q.action == ACT_CLEAR) ? CMD_STOP : CMD_RELEASE;
      pend.voice        <= idx_d_ext[3:0];
      pend.out_note     <= rd.note;
      pend.out_velocity <= '0;
      pend.out_zone     <= '0;
      pend.last         <= 1'b1;
    end else if (state == S_FINISH) begin
      if (emit_mode) begin
        result <= pend;
      end else begin
        result.command      <= sel_cmd;
        result.voice        <= sel_ext[3:0];
        result.out_note     <= req_q.note;
        result.out_velocity <= req_q.velocity;
        result.out_zone     <= req_q.zone_id & ZONE_MASK;
        result.last         <= 1'b1;
      end
    end
  end

endmodule
